// ----- rtl/assert_macros.svh -----
// assertion macros shared by the checker files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_PROP(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("assertion failed");

// expression must never be true outside reset
`define ASSERT_NEVER(label, clk, rstn, expr) \
    `ASSERT_PROP(label, clk, rstn, !(expr))

`endif

// ----- rtl/mks_pkg.sv -----
// types shared by the record sorter modules
package mks_pkg;

    localparam int NUM_W   = 16;
    localparam int DIFF_W  = 8;
    localparam int PRICE_W = 32;

    // packed so that the order number sits in the lowest bits
    typedef struct packed {
        logic [PRICE_W-1:0] price;
        logic [DIFF_W-1:0]  difficulty;
        logic [NUM_W-1:0]   number;
    } record_t;

    localparam int REC_W = $bits(record_t);

    typedef struct packed {
        logic insert;
        logic set_ovf;
        logic pop;
        logic clear;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic last;
    } status_t;

    // true when a must be placed strictly before b
    function automatic logic sorts_before(record_t a, record_t b);
        logic result;
        if (a.price != b.price) begin
            result = a.price > b.price;
        end else if (a.difficulty != b.difficulty) begin
            result = a.difficulty < b.difficulty;
        end else begin
            result = a.number < b.number;
        end
        return result;
    endfunction

endpackage

// ----- rtl/multi_key_record_sorter_top.sv -----
// Record sorter: each input transfer carries one order record and is inserted into a chain
// of MAX_ITEMS cells, every cell comparing the new record against its own contents in
// parallel, so records enter at one per cycle while s_tready is high. The order is higher
// price first, then lower difficulty code, then lower order number; fully equal records keep
// arrival order. The transfer marked tlast is stored like the others and then starts the
// drain: the stored records leave one per cycle from the head of the chain while m_tready is
// high, the last one with tlast, and s_tready stays low until the last result transfer.
// Records arriving while the chain is full are dropped and tuser is high on every result of
// that set.
module multi_key_record_sorter_top import mks_pkg::*; #(
    parameter int MAX_ITEMS = 64
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [REC_W-1:0] s_tdata,   // order_number, difficulty, price
    input  logic             s_tlast,   // final_record
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [REC_W-1:0] m_tdata,   // out_number, out_difficulty, out_price
    output logic             m_tlast,   // end_of_run
    output logic             m_tuser    // overflowed
);

    cmd_t    cmd;
    status_t status;
    record_t head_rec;

    mks_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    mks_datapath #(
        .MAX_ITEMS (MAX_ITEMS)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_rec   (record_t'(s_tdata)),
        .cmd      (cmd),
        .status   (status),
        .head_rec (head_rec),
        .overflow (m_tuser)
    );

    assign m_tdata = head_rec;
    assign m_tlast = status.last;

endmodule

// ----- rtl/mks_ctrl.sv -----
// controller: collects records until the final one, then drains the sorted chain
module mks_ctrl import mks_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_tvalid,
    input  logic    s_tlast,
    output logic    s_tready,
    output logic    m_tvalid,
    input  logic    m_tready,
    input  status_t status,
    output cmd_t    cmd
);

    typedef enum logic {
        ST_COLLECT,
        ST_EMIT
    } state_t;

    state_t state_reg, state_next;
    logic   s_tready_reg, s_tready_next;
    logic   m_tvalid_reg, m_tvalid_next;

    always_comb begin
        state_next    = state_reg;
        s_tready_next = s_tready_reg;
        m_tvalid_next = m_tvalid_reg;
        cmd           = '0;
        unique case (state_reg)
            ST_COLLECT: begin
                if (s_tvalid && s_tready_reg) begin
                    cmd.insert  = !status.full;
                    cmd.set_ovf = status.full;
                    if (s_tlast) begin
                        state_next    = ST_EMIT;
                        s_tready_next = 1'b0;
                        m_tvalid_next = 1'b1;
                    end
                end
            end
            ST_EMIT: begin
                if (m_tready) begin
                    cmd.pop = 1'b1;
                    if (status.last) begin
                        cmd.clear     = 1'b1;
                        state_next    = ST_COLLECT;
                        s_tready_next = 1'b1;
                        m_tvalid_next = 1'b0;
                    end
                end
            end
            default: begin
                state_next = ST_COLLECT;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_COLLECT;
            s_tready_reg <= 1'b1;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            s_tready_reg <= s_tready_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign s_tready = s_tready_reg;
    assign m_tvalid = m_tvalid_reg;

endmodule

// ----- rtl/mks_datapath.sv -----
// datapath: insertion chain of record cells with fill count and overflow flag
module mks_datapath import mks_pkg::*; #(
    parameter int MAX_ITEMS = 64
) (
    input  logic    aclk,
    input  logic    aresetn,
    input  record_t in_rec,
    input  cmd_t    cmd,
    output status_t status,
    output record_t head_rec,
    output logic    overflow
);

    localparam int CW = $clog2(MAX_ITEMS + 1);

    record_t              cell_reg  [MAX_ITEMS];
    record_t              cell_next [MAX_ITEMS];
    logic [MAX_ITEMS-1:0] take;
    logic [CW-1:0]        count_reg, count_next;
    logic                 ovf_reg, ovf_next;

    // take[i]: the new record lands at or above cell i, monotone along the chain
    for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
        localparam logic [CW-1:0] IDX = CW'(i);

        assign take[i] = (IDX < count_reg) ? sorts_before(in_rec, cell_reg[i]) : 1'b1;

        if (i == 0) begin : g_head
            always_comb begin
                cell_next[i] = cell_reg[i];
                if (cmd.insert) begin
                    if (take[i]) begin
                        cell_next[i] = in_rec;
                    end
                end else if (cmd.pop) begin
                    cell_next[i] = (MAX_ITEMS > 1) ? cell_reg[(i + 1) % MAX_ITEMS]
                                                   : cell_reg[i];
                end
            end
        end else begin : g_body
            always_comb begin
                cell_next[i] = cell_reg[i];
                if (cmd.insert) begin
                    if (take[i-1]) begin
                        cell_next[i] = cell_reg[i-1];
                    end else if (take[i]) begin
                        cell_next[i] = in_rec;
                    end
                end else if (cmd.pop) begin
                    if (i < MAX_ITEMS - 1) begin
                        cell_next[i] = cell_reg[(i + 1) % MAX_ITEMS];
                    end
                end
            end
        end

        always_ff @(posedge aclk) begin
            cell_reg[i] <= cell_next[i];
        end
    end

    always_comb begin
        count_next = count_reg;
        ovf_next   = ovf_reg;
        if (cmd.insert) begin
            count_next = count_reg + CW'(1);
        end else if (cmd.pop) begin
            count_next = count_reg - CW'(1);
        end
        if (cmd.set_ovf) begin
            ovf_next = 1'b1;
        end
        if (cmd.clear) begin
            count_next = '0;
            ovf_next   = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            ovf_reg   <= 1'b0;
        end else begin
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
        end
    end

    assign status.full = (count_reg == CW'(MAX_ITEMS));
    assign status.last = (count_reg == CW'(1));
    assign head_rec    = cell_reg[0];
    assign overflow    = ovf_reg;

endmodule

// ----- rtl/mks_checker.sv -----
// port-level checks for the record sorter, bound to the top level
`include "assert_macros.svh"

module mks_checker (
    input logic aclk,
    input logic aresetn,
    input logic s_tvalid,
    input logic s_tready,
    input logic s_tlast,
    input logic m_tvalid,
    input logic m_tready,
    input logic m_tlast
);

    // no input transfer is taken while results are draining
    `ASSERT_NEVER(a_no_accept_in_drain, aclk, aresetn, m_tvalid && s_tready)

    // a final record starts the drain in the next cycle
    `ASSERT_PROP(a_final_starts_drain, aclk, aresetn, (s_tvalid && s_tready && s_tlast) |=> m_tvalid)

    // the drain ends right after the last result transfer
    `ASSERT_PROP(a_last_ends_drain, aclk, aresetn, (m_tvalid && m_tready && m_tlast) |=> (!m_tvalid && s_tready))

    // a stalled result stays offered
    `ASSERT_PROP(a_valid_holds, aclk, aresetn, (m_tvalid && !m_tready) |=> m_tvalid)

endmodule

bind multi_key_record_sorter_top mks_checker u_mks_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tlast  (m_tlast)
);

// ----- sim/multi_key_record_sorter_top_test.sv -----
// self-checking testbench for the multi-key record sorter, directed table then random sets
`timescale 1ns / 100ps

module multi_key_record_sorter_top_test;
    import mks_pkg::*;

    localparam int STORE_DEPTH = 64;
    localparam int RANDOM_ITEMS = 480;
    localparam int LONG_HOLD = 500;

    typedef struct packed {
        record_t rec;
        logic    eor;
        logic    ovf;
    } sorted_out_t;

    typedef struct packed {
        logic [NUM_W-1:0]   number;
        logic [DIFF_W-1:0]  difficulty;
        logic [PRICE_W-1:0] price;
        logic               last;
        logic               typed;
    } stim_row_t;

    // typed rows are single-record sets, so the result is the record itself
    localparam int DIR_ROWS = 20;
    localparam stim_row_t DIR_TABLE [DIR_ROWS] = '{
        '{16'hffff, 8'hff, 32'hffff_ffff, 1'b1, 1'b1},
        '{16'h0000, 8'h00, 32'h0000_0000, 1'b1, 1'b1},
        '{16'h0005, 8'h41, 32'd100,       1'b0, 1'b0},
        '{16'h0003, 8'h41, 32'd100,       1'b0, 1'b0},
        '{16'h0004, 8'h40, 32'd100,       1'b0, 1'b0},
        '{16'h0001, 8'h42, 32'd200,       1'b0, 1'b0},
        '{16'hffff, 8'h00, 32'h0000_0000, 1'b0, 1'b0},
        '{16'h0003, 8'h41, 32'd100,       1'b0, 1'b0},
        '{16'h0000, 8'hff, 32'hffff_ffff, 1'b0, 1'b0},
        '{16'h0002, 8'h41, 32'd100,       1'b1, 1'b0},
        '{16'h1234, 8'h41, 32'h8000_0000, 1'b1, 1'b1},
        '{16'h0010, 8'h43, 32'd1,         1'b0, 1'b0},
        '{16'h0011, 8'h43, 32'd2,         1'b0, 1'b0},
        '{16'h0012, 8'h43, 32'd3,         1'b0, 1'b0},
        '{16'h0013, 8'h43, 32'hffff_fffe, 1'b0, 1'b0},
        '{16'h0014, 8'h43, 32'hffff_ffff, 1'b0, 1'b0},
        '{16'h0015, 8'h43, 32'h0000_0000, 1'b1, 1'b0},
        '{16'haaaa, 8'h55, 32'h5555_5555, 1'b0, 1'b0},
        '{16'h5555, 8'haa, 32'haaaa_aaaa, 1'b0, 1'b0},
        '{16'h0001, 8'h7f, 32'h7fff_ffff, 1'b1, 1'b0}
    };

    logic             aclk;
    logic             aresetn  = 1'b0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    logic [REC_W-1:0] s_tdata  = '0;   // order_number, difficulty, price
    logic             s_tlast  = 1'b0; // final_record
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [REC_W-1:0] m_tdata;         // out_number, out_difficulty, out_price
    logic             m_tlast;         // end_of_run
    logic             m_tuser;         // overflowed

    // predictor state
    record_t     sorted_store [STORE_DEPTH];
    int          stored_count = 0;
    logic        dropped_seen = 1'b0;
    sorted_out_t pending_results [$];

    int   mismatches = 0;
    int   results_seen = 0;
    bit   long_hold_done = 1'b0;
    bit   send_quiet = 1'b0;

    multi_key_record_sorter_top #(
        .MAX_ITEMS(STORE_DEPTH)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tlast (s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast),
        .m_tuser (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #3_000_000;
        $display("== FAIL ==");
        $finish;
    end

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        mismatches++;
        if (mismatches <= 40) begin
            $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
        end
    endtask

    // mostly short gaps, a few long ones, none at all in quiet stretches
    function automatic int pick_gap(bit quiet);
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic record_t make_record(bit tie_heavy);
        record_t r;
        r.price      = $urandom;
        r.difficulty = 8'($urandom);
        r.number     = 16'($urandom);
        if (tie_heavy) begin
            case ($urandom_range(0, 3))
                0: r.price = 32'h0000_0000;
                1: r.price = 32'hffff_ffff;
                2: r.price = 32'h0000_1000;
                default: ;
            endcase
            r.difficulty = ($urandom_range(0, 5) == 0) ? 8'hff : 8'(8'h40 + $urandom_range(0, 2));
            r.number = ($urandom_range(0, 7) == 0) ? 16'hffff : 16'($urandom_range(0, 5));
        end
        return r;
    endfunction

    // offer one record, wait for the transfer, then update the sorted store
    task automatic drive_record(record_t r, bit last, bit typed, sorted_out_t typed_exp);
        int gap;
        int pos;
        bit goes_first;
        gap = pick_gap(send_quiet);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= r;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);

        if (stored_count >= STORE_DEPTH) begin
            dropped_seen = 1'b1;
        end else begin
            // new record goes after every entry it does not strictly outrank
            pos = 0;
            goes_first = 1'b0;
            while (pos < stored_count && !goes_first) begin
                if (r.price != sorted_store[pos].price) begin
                    goes_first = r.price > sorted_store[pos].price;
                end else if (r.difficulty != sorted_store[pos].difficulty) begin
                    goes_first = r.difficulty < sorted_store[pos].difficulty;
                end else begin
                    goes_first = r.number < sorted_store[pos].number;
                end
                if (!goes_first) begin
                    pos++;
                end
            end
            for (int i = stored_count; i > pos; i--) begin
                sorted_store[i] = sorted_store[i-1];
            end
            sorted_store[pos] = r;
            stored_count++;
        end

        if (last) begin
            if (typed) begin
                pending_results.push_back(typed_exp);
            end else begin
                for (int i = 0; i < stored_count; i++) begin
                    pending_results.push_back('{sorted_store[i], i == stored_count - 1,
                                                dropped_seen});
                end
            end
            stored_count = 0;
            dropped_seen = 1'b0;
        end
    endtask

    // result side: random stalls plus one long hold-off while the sender keeps offering
    initial begin
        int gap;
        bit rx_quiet;
        rx_quiet = 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (!long_hold_done && results_seen >= 150) begin
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
                long_hold_done = 1'b1;
            end
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge aclk);
            gap = pick_gap(rx_quiet);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            rx_quiet = ($urandom_range(0, 4) == 0);
        end
    end

    always @(posedge aclk) begin
        sorted_out_t want;
        record_t     got;
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            got = record_t'(m_tdata);
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result", 64'(m_tdata), '0);
            end else begin
                want = pending_results.pop_front();
                if (got.number != want.rec.number) begin
                    report_mismatch("out_number", 64'(got.number), 64'(want.rec.number));
                end
                if (got.difficulty != want.rec.difficulty) begin
                    report_mismatch("out_difficulty", 64'(got.difficulty),
                                    64'(want.rec.difficulty));
                end
                if (got.price != want.rec.price) begin
                    report_mismatch("out_price", 64'(got.price), 64'(want.rec.price));
                end
                if (m_tlast !== want.eor) begin
                    report_mismatch("end_of_run", 64'(m_tlast), 64'(want.eor));
                end
                if (m_tuser !== want.ovf) begin
                    report_mismatch("overflowed", 64'(m_tuser), 64'(want.ovf));
                end
            end
        end
    end

    initial begin
        record_t     r;
        sorted_out_t typed_exp;
        int          random_items;
        int          set_idx;
        int          set_len;
        bit          tie_heavy;

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (DIR_TABLE[i]) begin
            r.number     = DIR_TABLE[i].number;
            r.difficulty = DIR_TABLE[i].difficulty;
            r.price      = DIR_TABLE[i].price;
            typed_exp    = '{r, 1'b1, 1'b0};
            drive_record(r, DIR_TABLE[i].last, DIR_TABLE[i].typed, typed_exp);
        end

        random_items = 0;
        set_idx = 0;
        while (random_items < RANDOM_ITEMS) begin
            // first set overfills the store and its final record is dropped
            if (set_idx == 0) begin
                set_len = STORE_DEPTH + 2;
            end else if ($urandom_range(0, 19) == 0) begin
                case ($urandom_range(0, 3))
                    0: set_len = STORE_DEPTH;
                    1: set_len = STORE_DEPTH + 1;
                    2: set_len = STORE_DEPTH + 6;
                    default: set_len = $urandom_range(30, STORE_DEPTH - 1);
                endcase
            end else begin
                set_len = $urandom_range(1, 12);
            end
            tie_heavy  = ($urandom_range(0, 1) == 0);
            send_quiet = ($urandom_range(0, 3) == 0);
            for (int k = 0; k < set_len; k++) begin
                drive_record(make_record(tie_heavy), k == set_len - 1, 1'b0, '0);
                random_items++;
            end
            // let the block drain completely once before carrying on
            if (set_idx == 4) begin
                s_tvalid <= 1'b0;
                do @(posedge aclk); while (pending_results.size() != 0);
            end
            set_idx++;
        end

        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending_results.size() != 0);
        repeat (20) @(posedge aclk);
        if (mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
